/* src/bounded_priority_queue_macros.svh */
// ----------------------------------------------------------------------------
// bounded_priority_queue_macros
// assertion macros for the bounded priority queue, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PRIORITY_QUEUE_MACROS_SVH
`define BOUNDED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on i_clk, off while in reset
`define BPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define BPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define BPQ_ASSERT_NOW(lbl, ante, cons, msg)
`define BPQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/bpq_pkg.sv */
// ----------------------------------------------------------------------------
// bpq_pkg
// types and constants shared by the bounded priority queue modules
// ----------------------------------------------------------------------------
package bpq_pkg;

    localparam int PRIO_W  = 16;
    localparam int TAG_W   = 16;
    localparam int KIND_W  = 3;
    localparam int SPACE_W = 10;
    localparam int COUNT_W = 6;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [SPACE_W-1:0] SPACING_RESET = 10'd10;
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = 16'sh7FFF;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = 16'sh8000;

    // register index, taken from paddr[2]
    localparam logic REG_SPACING = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT   = 3'd0,
        KIND_INS_HIGH = 3'd1,
        KIND_INS_LOW  = 3'd2,
        KIND_REMOVE   = 3'd3,
        KIND_CLEAR    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_REM,
        OP_CLR
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_APPLY,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
        logic                     flag;
    } t_entry;

    // broadcast to every cell of the row
    typedef struct packed {
        logic   ins;
        logic   rem;
        logic   low_mode;
        t_entry new_entry;
    } t_cell_ctl;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]         item_tag;
        logic                     steal_flag;
    } t_in_item;

    typedef struct packed {
        logic                     accepted;
        logic [TAG_W-1:0]         head_tag;
        logic signed [PRIO_W-1:0] head_priority;
        logic                     head_flag;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic signed [PRIO_W-1:0] top_bound;
        logic signed [PRIO_W-1:0] bottom_bound;
    } t_out_item;

endpackage

/* src/bpq_cell.sv */
// ----------------------------------------------------------------------------
// bpq_cell
// one slot of the sorted row: keeps, takes the new entry or shifts
// ----------------------------------------------------------------------------
module bpq_cell (
    input  logic               i_clk,
    input  bpq_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  logic               i_prev_keep,
    input  bpq_pkg::t_entry    i_prev_entry,
    input  bpq_pkg::t_entry    i_next_entry,
    output logic               o_keep,
    output bpq_pkg::t_entry    o_entry
);

    bpq_pkg::t_entry r_entry;
    bpq_pkg::t_entry n_entry;

    // a valid entry stays in place in low mode or when it ranks strictly above the new one
    assign o_keep = i_valid &&
                    (i_ctl.low_mode || (r_entry.prio > i_ctl.new_entry.prio));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !o_keep) begin
            n_entry = i_prev_keep ? i_ctl.new_entry : i_prev_entry;
        end else if (i_ctl.rem) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

/* src/bounded_priority_queue.sv */
// ----------------------------------------------------------------------------
// bounded_priority_queue
// sorted priority queue built as a row of shifting cells, head in cell 0
// ----------------------------------------------------------------------------
// usage:
//   input channel i_in_valid/o_in_ready carries one operation item (kind,
//   priority, tag, flag); output channel o_out_valid/i_out_ready returns one
//   result item per operation with the head, count, bounds and accept flag
//   each item passes through accept, priority compute, row update and result
//   load in that order, and its result is valid once the load step has run
//   a new item is taken only after the last one leaves the load step, as the
//   compute-then-shift sequence around the broadcast compare in the cell row
//   the output register frees the input side: a new item is taken while the
//   previous result still waits; a stalled receiver holds the next result
//   in the load step until the output register empties
//   reset empties the queue, zeroes both bounds and sets the spacing
//   register to 10; cell contents are not cleared, the count masks them
//   priority_spacing is written over the apb port at byte address 0
// ----------------------------------------------------------------------------
`include "bounded_priority_queue_macros.svh"

module bounded_priority_queue #(
    parameter int DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // operation input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bpq_pkg::t_in_item             i_in_item,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bpq_pkg::t_out_item            o_out_item,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpq_pkg::APB_AW-1:0]    paddr,
    input  logic [bpq_pkg::APB_DW-1:0]    pwdata,
    output logic [bpq_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int CW = $clog2(DEPTH + 1);

    // control
    bpq_pkg::t_state r_state;
    bpq_pkg::t_state n_state;
    logic            w_load_out;

    // latched input item and prepared operation
    bpq_pkg::t_in_item r_item;
    bpq_pkg::t_op      r_op;
    bpq_pkg::t_op      w_op;
    logic signed [bpq_pkg::PRIO_W-1:0] r_p;
    logic signed [bpq_pkg::PRIO_W-1:0] w_p;

    // tracked state
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic signed [bpq_pkg::PRIO_W-1:0] r_hi;
    logic signed [bpq_pkg::PRIO_W-1:0] n_hi;
    logic signed [bpq_pkg::PRIO_W-1:0] r_lo;
    logic signed [bpq_pkg::PRIO_W-1:0] n_lo;
    logic [bpq_pkg::SPACE_W-1:0]       r_spacing;

    // saturating relative priorities
    logic signed [bpq_pkg::PRIO_W:0]   w_hi_sum;
    logic signed [bpq_pkg::PRIO_W:0]   w_lo_diff;
    logic signed [bpq_pkg::PRIO_W-1:0] w_hi_sat;
    logic signed [bpq_pkg::PRIO_W-1:0] w_lo_sat;
    logic w_full;
    logic w_empty;

    // cell row
    bpq_pkg::t_cell_ctl w_ctl;
    logic [DEPTH-1:0]   w_valid;
    logic [DEPTH-1:0]   w_keep;
    bpq_pkg::t_entry    w_entry [DEPTH];

    // output register
    logic               r_out_valid;
    bpq_pkg::t_out_item r_out;

    // ------------------------------------------------------------------
    // apb configuration port, lower address bits ignored
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= bpq_pkg::SPACING_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == bpq_pkg::REG_SPACING)) begin
            r_spacing <= pwdata[bpq_pkg::SPACE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == bpq_pkg::REG_SPACING) begin
            prdata = {{(bpq_pkg::APB_DW - bpq_pkg::SPACE_W){1'b0}}, r_spacing};
        end
    end

    // ------------------------------------------------------------------
    // sequencer: idle -> prep -> apply -> resp
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            bpq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = bpq_pkg::ST_PREP;
                end
            end
            bpq_pkg::ST_PREP: begin
                n_state = bpq_pkg::ST_APPLY;
            end
            bpq_pkg::ST_APPLY: begin
                n_state = bpq_pkg::ST_RESP;
            end
            bpq_pkg::ST_RESP: begin
                // wait here while the previous result is still held
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = bpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in_item;
        end
    end

    // ------------------------------------------------------------------
    // prep: work out the insert priority and whether the op goes ahead
    // ------------------------------------------------------------------
    assign w_hi_sum  = $signed({r_hi[bpq_pkg::PRIO_W-1], r_hi}) +
                       $signed({{(bpq_pkg::PRIO_W + 1 - bpq_pkg::SPACE_W){1'b0}},
                                r_spacing});
    assign w_lo_diff = $signed({r_lo[bpq_pkg::PRIO_W-1], r_lo}) -
                       $signed({{(bpq_pkg::PRIO_W + 1 - bpq_pkg::SPACE_W){1'b0}},
                                r_spacing});
    // a sum out of 16-bit range shows as the two top bits differing
    assign w_hi_sat = (w_hi_sum[bpq_pkg::PRIO_W] != w_hi_sum[bpq_pkg::PRIO_W-1])
                    ? bpq_pkg::PRIO_MAX : w_hi_sum[bpq_pkg::PRIO_W-1:0];
    assign w_lo_sat = (w_lo_diff[bpq_pkg::PRIO_W] != w_lo_diff[bpq_pkg::PRIO_W-1])
                    ? bpq_pkg::PRIO_MIN : w_lo_diff[bpq_pkg::PRIO_W-1:0];

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_p  = r_item.priority_req;
        w_op = bpq_pkg::OP_NONE;
        case (r_item.kind)
            bpq_pkg::KIND_INSERT: begin
                w_op = w_full ? bpq_pkg::OP_NONE : bpq_pkg::OP_INS;
            end
            bpq_pkg::KIND_INS_HIGH: begin
                w_p  = w_hi_sat;
                w_op = w_full ? bpq_pkg::OP_NONE : bpq_pkg::OP_INS;
            end
            bpq_pkg::KIND_INS_LOW: begin
                w_p  = w_lo_sat;
                w_op = w_full ? bpq_pkg::OP_NONE : bpq_pkg::OP_INS;
            end
            bpq_pkg::KIND_REMOVE: begin
                w_op = w_empty ? bpq_pkg::OP_NONE : bpq_pkg::OP_REM;
            end
            bpq_pkg::KIND_CLEAR: begin
                w_op = bpq_pkg::OP_CLR;
            end
            default: begin
                w_op = bpq_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= bpq_pkg::OP_NONE;
        end else if (r_state == bpq_pkg::ST_PREP) begin
            r_op <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bpq_pkg::ST_PREP) begin
            r_p <= w_p;
        end
    end

    // ------------------------------------------------------------------
    // apply: broadcast to the cell row, update count and bounds
    // ------------------------------------------------------------------
    // at or below the lowest bound the new entry goes under all held ones
    assign w_ctl.ins       = (r_state == bpq_pkg::ST_APPLY) && (r_op == bpq_pkg::OP_INS);
    assign w_ctl.rem       = (r_state == bpq_pkg::ST_APPLY) && (r_op == bpq_pkg::OP_REM);
    assign w_ctl.low_mode  = (r_p <= r_lo);
    assign w_ctl.new_entry = '{prio: r_p, tag: r_item.item_tag, flag: r_item.steal_flag};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bpq_pkg::t_entry w_prev;
        bpq_pkg::t_entry w_next;
        logic            w_prev_keep;

        assign w_valid[g] = (r_count > CW'(g));

        // head cell takes the new entry whenever it gives way
        if (g == 0) begin : g_head
            assign w_prev_keep = 1'b1;
            assign w_prev      = w_ctl.new_entry;
        end else begin : g_mid
            assign w_prev_keep = w_keep[g-1];
            assign w_prev      = w_entry[g-1];
        end

        // tail cell has nothing behind it on a removal
        if (g == DEPTH - 1) begin : g_tail
            assign w_next = w_entry[g];
        end else begin : g_body
            assign w_next = w_entry[g+1];
        end

        bpq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (w_valid[g]),
            .i_prev_keep  (w_prev_keep),
            .i_prev_entry (w_prev),
            .i_next_entry (w_next),
            .o_keep       (w_keep[g]),
            .o_entry      (w_entry[g])
        );
    end

    always_comb begin
        n_count = r_count;
        n_hi    = r_hi;
        n_lo    = r_lo;
        if (r_state == bpq_pkg::ST_APPLY) begin
            case (r_op)
                bpq_pkg::OP_INS: begin
                    n_count = r_count + CW'(1);
                    if (w_empty) begin
                        // first entry sets both bounds
                        n_hi = r_p;
                        n_lo = r_p;
                    end else begin
                        n_hi = (r_p > r_hi) ? r_p : r_hi;
                        n_lo = (r_p < r_lo) ? r_p : r_lo;
                    end
                end
                bpq_pkg::OP_REM: begin
                    n_count = r_count - CW'(1);
                    if (r_count != CW'(1)) begin
                        // highest follows the new head, lowest is kept
                        n_hi = w_entry[1].prio;
                    end else begin
                        n_hi = '0;
                        n_lo = '0;
                    end
                end
                bpq_pkg::OP_CLR: begin
                    n_count = '0;
                    n_hi    = '0;
                    n_lo    = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hi    <= '0;
            r_lo    <= '0;
        end else begin
            r_count <= n_count;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
        end
    end

    // ------------------------------------------------------------------
    // resp: output register, head fields read as zero when empty
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.accepted      <= (r_op != bpq_pkg::OP_NONE);
            r_out.head_tag      <= w_empty ? '0 : w_entry[0].tag;
            r_out.head_priority <= w_empty ? '0 : w_entry[0].prio;
            r_out.head_flag     <= w_empty ? 1'b0 : w_entry[0].flag;
            r_out.entry_count   <= bpq_pkg::COUNT_W'(r_count);
            r_out.is_empty      <= w_empty;
            r_out.top_bound     <= r_hi;
            r_out.bottom_bound  <= r_lo;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `BPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "count above depth")
    `BPQ_ASSERT_NOW(a_empty_bounds, w_empty, (r_hi == '0) && (r_lo == '0), "bounds not zero when empty")
    `BPQ_ASSERT_NOW(a_bound_order, !w_empty, r_lo <= r_hi, "lowest bound above highest bound")
    `BPQ_ASSERT_NOW(a_head_order, r_count >= CW'(2), w_entry[0].prio >= w_entry[1].prio, "head below second entry")
    `BPQ_ASSERT_NEXT(a_no_drop, (r_state == bpq_pkg::ST_RESP) && r_out_valid && !i_out_ready, (r_state == bpq_pkg::ST_RESP) && r_out_valid, "result lost while receiver stalled")

endmodule

/* test/bounded_priority_queue_test.sv */
// ----------------------------------------------------------------------------
// bounded_priority_queue_test
// self-checking bench for the bounded priority queue: a directed table of
// operations, then random runs that fill, churn and drain the store under
// several spacing settings, checked against typed rows or a local queue model
// ----------------------------------------------------------------------------
module bounded_priority_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 5;
    localparam int DIR_ROWS      = 25;

    // kinds that the block must ignore
    localparam logic [bpq_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [bpq_pkg::KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [bpq_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    localparam logic [bpq_pkg::APB_AW-1:0] SPACING_ADDR = {bpq_pkg::REG_SPACING, 2'b00};

    // operation mix of a random segment
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } t_mix;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct {
        bpq_pkg::t_in_item  op;
        bit                 typed;
        bpq_pkg::t_out_item want;
    } t_dir_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    bpq_pkg::t_in_item          i_in_item;
    logic                       o_out_valid;
    logic                       i_out_ready;
    bpq_pkg::t_out_item         o_out_item;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [bpq_pkg::APB_AW-1:0] paddr;
    logic [bpq_pkg::APB_DW-1:0] pwdata;
    logic [bpq_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    bounded_priority_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // queue model: entries in ascending priority order, head at the back
    // ------------------------------------------------------------------------
    bpq_pkg::t_entry                   held_entries[$];
    logic signed [bpq_pkg::PRIO_W-1:0] top_seen    = '0;
    logic signed [bpq_pkg::PRIO_W-1:0] bottom_seen = '0;
    logic [bpq_pkg::SPACE_W-1:0]       spacing     = bpq_pkg::SPACING_RESET;

    // results still owed by the block, oldest first
    bpq_pkg::t_out_item awaited_status[$];

    // hand-written result for the item now on the input, if any
    bit                 typed_valid  = 1'b0;
    bpq_pkg::t_out_item typed_result = '0;

    bit quiet = 1'b0;   // no idling on either side
    int fail_count   = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int rejected_ops = 0;
    int peak_fill    = 0;
    int cycle_count  = 0;

    // place one entry; false when the store is full
    function automatic bit place_entry(logic signed [bpq_pkg::PRIO_W-1:0] p,
                                       logic [bpq_pkg::TAG_W-1:0] tag, logic flag);
        int              pos;
        bpq_pkg::t_entry e;
        pos = 0;
        if (held_entries.size() >= DEPTH)
            return 1'b0;
        if (held_entries.size() == 0) begin
            top_seen    = p;
            bottom_seen = p;
        end
        // at or below the low bound it goes underneath its equals,
        // otherwise above every entry not greater than itself
        if (p > bottom_seen) begin
            foreach (held_entries[i])
                if (held_entries[i].prio <= p)
                    pos = i + 1;
        end
        e.prio = p;
        e.tag  = tag;
        e.flag = flag;
        held_entries.insert(pos, e);
        if (p > top_seen)
            top_seen = p;
        if (p < bottom_seen)
            bottom_seen = p;
        return 1'b1;
    endfunction

    // apply one operation to the model and return the status it reports
    function automatic bpq_pkg::t_out_item predict_queue_op(bpq_pkg::t_in_item it);
        bpq_pkg::t_out_item r;
        bit                 ok;
        int                 step;
        int                 target;
        r    = '0;
        ok   = 1'b0;
        step = spacing;
        case (it.kind)
            bpq_pkg::KIND_INSERT: begin
                ok = place_entry(it.priority_req, it.item_tag, it.steal_flag);
            end
            bpq_pkg::KIND_INS_HIGH: begin
                target = top_seen;
                target = target + step;
                if (target > 32767)
                    target = 32767;
                ok = place_entry(bpq_pkg::PRIO_W'(target), it.item_tag, it.steal_flag);
            end
            bpq_pkg::KIND_INS_LOW: begin
                target = bottom_seen;
                target = target - step;
                if (target < -32768)
                    target = -32768;
                ok = place_entry(bpq_pkg::PRIO_W'(target), it.item_tag, it.steal_flag);
            end
            bpq_pkg::KIND_REMOVE: begin
                if (held_entries.size() > 0) begin
                    held_entries.delete(held_entries.size() - 1);
                    // the high bound follows the new head, the low bound stays
                    if (held_entries.size() > 0) begin
                        top_seen = held_entries[held_entries.size() - 1].prio;
                    end else begin
                        top_seen    = '0;
                        bottom_seen = '0;
                    end
                    ok = 1'b1;
                end
            end
            bpq_pkg::KIND_CLEAR: begin
                held_entries.delete();
                top_seen    = '0;
                bottom_seen = '0;
                ok          = 1'b1;
            end
            default: begin
                // unused kinds leave everything alone
            end
        endcase
        r.accepted = ok;
        if (held_entries.size() > 0) begin
            r.head_tag      = held_entries[held_entries.size() - 1].tag;
            r.head_priority = held_entries[held_entries.size() - 1].prio;
            r.head_flag     = held_entries[held_entries.size() - 1].flag;
        end
        r.entry_count  = bpq_pkg::COUNT_W'(held_entries.size());
        r.is_empty     = (held_entries.size() == 0);
        r.top_bound    = top_seen;
        r.bottom_bound = bottom_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_status(bpq_pkg::t_out_item got);
        bpq_pkg::t_out_item want;
        if (awaited_status.size() == 0) begin
            $error("result item with no operation outstanding");
            fail_count++;
            return;
        end
        want = awaited_status.pop_front();
        check_field("accepted", want.accepted, got.accepted);
        check_field("head_tag", want.head_tag, got.head_tag);
        check_field("head_priority", want.head_priority, got.head_priority);
        check_field("head_flag", want.head_flag, got.head_flag);
        check_field("entry_count", want.entry_count, got.entry_count);
        check_field("is_empty", want.is_empty, got.is_empty);
        check_field("top_bound", want.top_bound, got.top_bound);
        check_field("bottom_bound", want.bottom_bound, got.bottom_bound);
    endtask

    // both channels sampled at the rising edge; a result leaving in the same
    // cycle as a new item belongs to an older item, so check it first
    always @(posedge i_clk) begin
        bpq_pkg::t_out_item predicted;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                check_status(o_out_item);
                results_seen++;
            end
            if (i_in_valid && o_in_ready) begin
                predicted = predict_queue_op(i_in_item);
                awaited_status.insert(awaited_status.size(),
                                      typed_valid ? typed_result : predicted);
                items_taken++;
                if (!predicted.accepted && i_in_item.kind <= bpq_pkg::KIND_CLEAR)
                    rejected_ops++;
                if (held_entries.size() > peak_fill)
                    peak_fill = held_entries.size();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_status.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // clock and receiver pacing
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: ready stretches mixed with stall bursts
    initial begin
        int span;
        i_out_ready = 1'b1;
        forever begin
            span = $urandom_range(1, 30);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_ready = 1'b0;
                span        = $urandom_range(1, 18);
            end else begin
                i_out_ready = 1'b1;
            end
            repeat (span) @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers; all called and returning at a falling edge
    // ------------------------------------------------------------------------
    function automatic bpq_pkg::t_in_item make_op(
            logic [bpq_pkg::KIND_W-1:0] kind,
            logic signed [bpq_pkg::PRIO_W-1:0] prio,
            logic [bpq_pkg::TAG_W-1:0] tag, logic flag);
        bpq_pkg::t_in_item it;
        it.kind         = kind;
        it.priority_req = prio;
        it.item_tag     = tag;
        it.steal_flag   = flag;
        return it;
    endfunction

    function automatic bpq_pkg::t_out_item status_of(
            bit acc, logic [bpq_pkg::TAG_W-1:0] tag,
            logic signed [bpq_pkg::PRIO_W-1:0] prio,
            logic flag, int cnt,
            logic signed [bpq_pkg::PRIO_W-1:0] top,
            logic signed [bpq_pkg::PRIO_W-1:0] bot);
        bpq_pkg::t_out_item r;
        r.accepted      = acc;
        r.head_tag      = tag;
        r.head_priority = prio;
        r.head_flag     = flag;
        r.entry_count   = bpq_pkg::COUNT_W'(cnt);
        r.is_empty      = (cnt == 0);
        r.top_bound     = top;
        r.bottom_bound  = bot;
        return r;
    endfunction

    function automatic t_dir_row dir_row(bpq_pkg::t_in_item op, bit typed = 1'b0,
                                         bpq_pkg::t_out_item want = '0);
        t_dir_row row;
        row.op    = op;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // random priority: extremes, a narrow band for ties, or anything
    function automatic logic signed [bpq_pkg::PRIO_W-1:0] random_priority();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return bpq_pkg::PRIO_MAX;
        if (pick < 20)
            return bpq_pkg::PRIO_MIN;
        if (pick < 60)
            return bpq_pkg::PRIO_W'($urandom_range(0, 6) - 3);
        return bpq_pkg::PRIO_W'($urandom_range(0, 65535));
    endfunction

    function automatic bpq_pkg::t_in_item random_op(t_mix mix);
        logic [bpq_pkg::KIND_W-1:0] kind;
        int                         pick;
        int                         ins_pct;
        int                         rem_pct;
        int                         clr_pct;
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:     begin ins_pct = 92; rem_pct = 6;  clr_pct = 0; end
            MIX_DRAIN:    begin ins_pct = 10; rem_pct = 88; clr_pct = 0; end
            default:      begin ins_pct = 55; rem_pct = 35; clr_pct = 4; end
        endcase
        if (pick < ins_pct) begin
            case ($urandom_range(0, 4))
                0, 1, 2: kind = bpq_pkg::KIND_INSERT;
                3:       kind = bpq_pkg::KIND_INS_HIGH;
                default: kind = bpq_pkg::KIND_INS_LOW;
            endcase
        end else if (pick < ins_pct + rem_pct) begin
            kind = bpq_pkg::KIND_REMOVE;
        end else if (pick < ins_pct + rem_pct + clr_pct) begin
            kind = bpq_pkg::KIND_CLEAR;
        end else begin
            kind = bpq_pkg::KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        end
        return make_op(kind, random_priority(),
                       bpq_pkg::TAG_W'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)));
    endfunction

    // present one item, optionally after an idle burst, and hold it until taken
    task automatic send_item(bpq_pkg::t_in_item it, bit typed, bpq_pkg::t_out_item want);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            gap        = $urandom_range(1, 18);
            repeat (gap) @(negedge i_clk);
        end
        i_in_item    = it;
        typed_valid  = typed;
        typed_result = want;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // stop sending, wait for every owed result, then let the block settle
    task automatic drain_and_settle();
        i_in_valid = 1'b0;
        while (awaited_status.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic read_spacing(output logic [bpq_pkg::SPACE_W-1:0] value);
        paddr   = SPACING_ADDR;
        pwrite  = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata[bpq_pkg::SPACE_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // write the spacing register, read it back, and follow it in the model
    task automatic write_spacing(logic [bpq_pkg::SPACE_W-1:0] value);
        logic [bpq_pkg::SPACE_W-1:0] readback;
        paddr   = SPACING_ADDR;
        pwdata  = bpq_pkg::APB_DW'(value);
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        spacing = value;
        read_spacing(readback);
        check_field("priority_spacing", value, readback);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_dir_row                    directed_rows [DIR_ROWS];
        logic [bpq_pkg::SPACE_W-1:0] reset_spacing;
        logic [bpq_pkg::SPACE_W-1:0] phase_spacing;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        read_spacing(reset_spacing);
        check_field("priority_spacing", bpq_pkg::SPACING_RESET, reset_spacing);

        // directed table at the reset spacing of 10
        directed_rows = '{
            // removal and clear on an empty store, then an ignored kind
            dir_row(make_op(bpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000, 1'b0),
                    1'b1, status_of(1'b0, 16'h0000, 16'sd0, 1'b0, 0, 16'sd0, 16'sd0)),
            dir_row(make_op(bpq_pkg::KIND_CLEAR, 16'sd0, 16'h0000, 1'b0),
                    1'b1, status_of(1'b1, 16'h0000, 16'sd0, 1'b0, 0, 16'sd0, 16'sd0)),
            dir_row(make_op(KIND_SPARE_FIRST, bpq_pkg::PRIO_MIN, 16'hFFFF, 1'b1),
                    1'b1, status_of(1'b0, 16'h0000, 16'sd0, 1'b0, 0, 16'sd0, 16'sd0)),
            // top extreme, then a relative insert that saturates onto it
            // and lands underneath as it equals the low bound
            dir_row(make_op(bpq_pkg::KIND_INSERT, bpq_pkg::PRIO_MAX, 16'hFFFF, 1'b1),
                    1'b1, status_of(1'b1, 16'hFFFF, bpq_pkg::PRIO_MAX, 1'b1, 1,
                                    bpq_pkg::PRIO_MAX, bpq_pkg::PRIO_MAX)),
            dir_row(make_op(bpq_pkg::KIND_INS_HIGH, 16'sd0, 16'h1111, 1'b0),
                    1'b1, status_of(1'b1, 16'hFFFF, bpq_pkg::PRIO_MAX, 1'b1, 2,
                                    bpq_pkg::PRIO_MAX, bpq_pkg::PRIO_MAX)),
            // bottom extreme, then low insert saturating at the minimum
            dir_row(make_op(bpq_pkg::KIND_INSERT, bpq_pkg::PRIO_MIN, 16'h0000, 1'b0),
                    1'b1, status_of(1'b1, 16'hFFFF, bpq_pkg::PRIO_MAX, 1'b1, 3,
                                    bpq_pkg::PRIO_MAX, bpq_pkg::PRIO_MIN)),
            dir_row(make_op(bpq_pkg::KIND_INS_LOW, 16'sd0, 16'h2222, 1'b1),
                    1'b1, status_of(1'b1, 16'hFFFF, bpq_pkg::PRIO_MAX, 1'b1, 4,
                                    bpq_pkg::PRIO_MAX, bpq_pkg::PRIO_MIN)),
            // middle entries with a tie, the newer one goes above
            dir_row(make_op(bpq_pkg::KIND_INSERT, 16'sd0, 16'h3333, 1'b0)),
            dir_row(make_op(bpq_pkg::KIND_INSERT, 16'sd0, 16'h4444, 1'b1)),
            dir_row(make_op(KIND_SPARE_MID, 16'sd7, 16'hAAAA, 1'b1)),
            dir_row(make_op(bpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000, 1'b0)),
            dir_row(make_op(bpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000, 1'b0)),
            dir_row(make_op(bpq_pkg::KIND_CLEAR, 16'sd0, 16'h0000, 1'b0),
                    1'b1, status_of(1'b1, 16'h0000, 16'sd0, 1'b0, 0, 16'sd0, 16'sd0)),
            // fresh store: ties on the low and the high bound, relative inserts
            dir_row(make_op(bpq_pkg::KIND_INSERT, -16'sd5, 16'h5555, 1'b1),
                    1'b1, status_of(1'b1, 16'h5555, -16'sd5, 1'b1, 1, -16'sd5, -16'sd5)),
            dir_row(make_op(bpq_pkg::KIND_INSERT, -16'sd5, 16'h6666, 1'b0)),
            dir_row(make_op(bpq_pkg::KIND_INS_HIGH, 16'sd0, 16'h7777, 1'b0)),
            dir_row(make_op(bpq_pkg::KIND_INS_LOW, 16'sd0, 16'h8888, 1'b1)),
            dir_row(make_op(bpq_pkg::KIND_INSERT, 16'sd5, 16'h9999, 1'b1)),
            dir_row(make_op(KIND_SPARE_LAST, bpq_pkg::PRIO_MAX, 16'h5A5A, 1'b0)),
            // drain to empty; the removal that empties the store returns both bounds to zero
            dir_row(make_op(bpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000, 1'b0)),
            dir_row(make_op(bpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000, 1'b0)),
            dir_row(make_op(bpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000, 1'b0)),
            dir_row(make_op(bpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000, 1'b0)),
            dir_row(make_op(bpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000, 1'b0),
                    1'b1, status_of(1'b1, 16'h0000, 16'sd0, 1'b0, 0, 16'sd0, 16'sd0)),
            dir_row(make_op(bpq_pkg::KIND_REMOVE, 16'sd0, 16'h0000, 1'b0),
                    1'b1, status_of(1'b0, 16'h0000, 16'sd0, 1'b0, 0, 16'sd0, 16'sd0))
        };
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);

        // random phases: widest spacing, narrowest, zero, a random one, reset
        // value; each fills past full, churns, then drains past empty
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       phase_spacing = 10'd1023;
                1:       phase_spacing = 10'd1;
                2:       phase_spacing = 10'd0;
                3:       phase_spacing = bpq_pkg::SPACE_W'($urandom_range(2, 1022));
                default: phase_spacing = bpq_pkg::SPACING_RESET;
            endcase
            drain_and_settle();
            write_spacing(phase_spacing);
            if (ph == PHASES - 1)
                quiet = 1'b1;
            repeat (45) send_item(random_op(MIX_FILL), 1'b0, '0);
            repeat (35) send_item(random_op(MIX_BALANCED), 1'b0, '0);
            repeat (40) send_item(random_op(MIX_DRAIN), 1'b0, '0);
        end

        drain_and_settle();
        $display("ran %0d items with %0d results under %0d spacing settings",
                 items_taken, results_seen, PHASES + 1);
        $display("%0d operations refused on a full or empty store, peak fill %0d of %0d",
                 rejected_ops, peak_fill, DEPTH);
        if (fail_count == 0 && awaited_status.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* bounded_priority_queue.f */
+incdir+src
src/bpq_pkg.sv
src/bpq_cell.sv
src/bounded_priority_queue.sv
test/bounded_priority_queue_test.sv
